// ===== design/stkalloc_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack allocator package
// Shared widths, constants and request codes of the stack allocator.
// ----------------------------------------------------------------------------
package stkalloc_pkg;

  localparam int unsigned HeaderBytes = 1;
  localparam int unsigned StackDepth  = 64;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned SizeW  = 21;
  localparam int unsigned AlignW = 13;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CntW   = $clog2(StackDepth + 1);
  localparam int unsigned IdxW   = $clog2(StackDepth);
  localparam int unsigned EndW   = SizeW + 2;

  localparam int unsigned InTdataW  = 72;
  localparam int unsigned OutTdataW = 80;

  localparam int unsigned RegRegionReset = 65536;

  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic {
    REG_BASE   = 1'b0,
    REG_REGION = 1'b1
  } reg_e;

endpackage

// ===== design/stack_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Stack allocator
// Bump allocator with aligned blocks, header room and LIFO free.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel (tuser carries the mode: allocate,
//   free, clear all, no operation) and each gives exactly one response on
//   the m_axis channel with the block address, granted flag, used and peak
//   byte counts. The user must set base address and region size through the
//   APB port only while no request is in flight; the block does not enforce
//   this. Both read back. Responses are registered, and one request is taken
//   every cycle while the receiver keeps up. The paddings of live blocks sit
//   in a 64-entry memory with the top entry held in a register and the one
//   below it prefetched each cycle, so back-to-back frees do not stall.
//   Reset empties the stack, clears used and peak counts, sets the base to 0
//   and the region to 65536 bytes. No memory clearing pass is run.
//   When the receiver stalls, the response register holds and s_axis_tready_o
//   stays high only while the waiting response is taken in the same cycle.
// ----------------------------------------------------------------------------
module stack_allocator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // request_bytes[20:0], align_bytes[33:21], release_address[65:34]
  input  logic [stkalloc_pkg::InTdataW-1:0]   s_axis_tdata_i,
  // mode[1:0]
  input  logic [stkalloc_pkg::ModeW-1:0]      s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // block_address[31:0], used_bytes[52:32], peak_bytes[73:53]
  output logic [stkalloc_pkg::OutTdataW-1:0]  m_axis_tdata_o,
  // granted[0]
  output logic                                m_axis_tuser_o,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [2:0]                          paddr_i,
  input  logic [31:0]                         pwdata_i,
  output logic [31:0]                         prdata_o,
  output logic                                pready_o
);

  localparam int unsigned AW = stkalloc_pkg::AddrW;
  localparam int unsigned SW = stkalloc_pkg::SizeW;
  localparam int unsigned GW = stkalloc_pkg::AlignW;
  localparam int unsigned CW = stkalloc_pkg::CntW;
  localparam int unsigned IW = stkalloc_pkg::IdxW;
  localparam int unsigned EW = stkalloc_pkg::EndW;

  // configuration
  logic [AW-1:0] base_q;
  logic [SW-1:0] region_q;
  logic          cfg_wr;
  stkalloc_pkg::reg_e cfg_sel;

  // state
  logic [SW-1:0] top_q, top_d;
  logic [SW-1:0] peak_q, peak_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [GW-1:0] tos_q, tos_d;
  logic [GW-1:0] below_q;
  logic [GW-1:0] pad_mem [stkalloc_pkg::StackDepth];
  logic [IW-1:0] rd_idx;
  logic [CW-1:0] rd_cnt;
  logic          push;

  // request fields
  stkalloc_pkg::mode_e mode;
  logic [SW-1:0] req_bytes;
  logic [GW-1:0] align_in;
  logic [AW-1:0] rel_addr;
  logic          in_acc;

  // datapath
  logic [GW-1:0] align_p2, align_m, pad_raw, pad, need;
  logic [AW-1:0] cur_addr;
  logic [EW-1:0] end_off;
  logic [AW-1:0] free_off;
  logic          grant;
  logic [AW-1:0] blk_addr;

  // response register
  logic                                 out_vld_q, out_vld_d;
  logic [stkalloc_pkg::OutTdataW-1:0]   out_data_q;
  logic                                 out_grant_q;

  assign mode      = stkalloc_pkg::mode_e'(s_axis_tuser_i);
  assign req_bytes = s_axis_tdata_i[20:0];
  assign align_in  = s_axis_tdata_i[33:21];
  assign rel_addr  = s_axis_tdata_i[65:34];

  assign s_axis_tready_o = ~out_vld_q | m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;

  // APB
  assign pready_o = 1'b1;
  assign cfg_sel  = stkalloc_pkg::reg_e'(paddr_i[2]);
  assign cfg_wr   = psel_i & penable_i & pwrite_i;

  always_comb begin
    unique case (cfg_sel)
      stkalloc_pkg::REG_BASE:   prdata_o = base_q;
      stkalloc_pkg::REG_REGION: prdata_o = {{(32-SW){1'b0}}, region_q};
      default:                  prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      region_q <= SW'(stkalloc_pkg::RegRegionReset);
    end else if (cfg_wr) begin
      if (cfg_sel == stkalloc_pkg::REG_BASE) begin
        base_q <= pwdata_i;
      end else begin
        region_q <= pwdata_i[SW-1:0];
      end
    end
  end

  // alignment: highest set bit, zero treated as one
  always_comb begin
    align_p2 = GW'(1);
    for (int i = 0; i < GW; i++) begin
      if (align_in[i]) begin
        align_p2 = GW'(1) << i;
      end
    end
  end

  assign align_m  = align_p2 - GW'(1);
  assign cur_addr = base_q + {{(AW-SW){1'b0}}, top_q};
  assign pad_raw  = (align_p2 - (cur_addr[GW-1:0] & align_m)) & align_m;

  // short of header room: add whole alignment steps
  always_comb begin
    need = GW'(stkalloc_pkg::HeaderBytes) - pad_raw;
    if (pad_raw < GW'(stkalloc_pkg::HeaderBytes)) begin
      pad = pad_raw + ((need + align_m) & ~align_m);
    end else begin
      pad = pad_raw;
    end
  end

  assign end_off  = {2'b00, top_q} + {{(EW-GW){1'b0}}, pad} + {2'b00, req_bytes};
  assign free_off = rel_addr - {{(AW-GW){1'b0}}, tos_q} - base_q;
  assign blk_addr = cur_addr + {{(AW-GW){1'b0}}, pad};

  always_comb begin
    top_d  = top_q;
    peak_d = peak_q;
    cnt_d  = cnt_q;
    tos_d  = tos_q;
    grant  = 1'b0;
    push   = 1'b0;
    if (in_acc) begin
      case (mode)
        stkalloc_pkg::MODE_ALLOC: begin
          if (cnt_q < CW'(stkalloc_pkg::StackDepth) && end_off <= {2'b00, region_q}) begin
            grant = 1'b1;
            push  = 1'b1;
            top_d = end_off[SW-1:0];
            cnt_d = cnt_q + CW'(1);
            tos_d = pad;
            if (end_off[SW-1:0] > peak_q) begin
              peak_d = end_off[SW-1:0];
            end
          end
        end
        stkalloc_pkg::MODE_FREE: begin
          if (cnt_q != '0 && free_off <= {{(AW-SW){1'b0}}, top_q}) begin
            grant = 1'b1;
            top_d = free_off[SW-1:0];
            cnt_d = cnt_q - CW'(1);
            tos_d = below_q;
          end
        end
        stkalloc_pkg::MODE_CLEAR: begin
          grant  = 1'b1;
          top_d  = '0;
          peak_d = '0;
          cnt_d  = '0;
        end
        default: begin
          grant = 1'b0;
        end
      endcase
    end
  end

  // prefetch the entry under the next top
  assign rd_cnt = cnt_d - CW'(2);
  assign rd_idx = rd_cnt[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (push) begin
      pad_mem[cnt_q[IW-1:0]] <= pad;
    end
    below_q <= pad_mem[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      peak_q <= '0;
      cnt_q  <= '0;
    end else begin
      top_q  <= top_d;
      peak_q <= peak_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
  end

  // response
  assign out_vld_d = in_acc | (out_vld_q & ~m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q  <= {6'b0, peak_d, top_d, (grant && mode == stkalloc_pkg::MODE_ALLOC) ?
                      blk_addr : {AW{1'b0}}};
      out_grant_q <= grant;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_grant_q;

`ifndef SYNTHESIS
  a_peak_ge_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= top_q) else $error("peak below top");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(stkalloc_pkg::StackDepth)) else $error("stack count overflow");

  a_push_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> cnt_q == $past(cnt_q) + CW'(1)) else $error("push count mismatch");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_vld_q) else $error("response lost");
`endif

endmodule
